/* src/gf2m_pkg.sv */
package gf2m_pkg;

    localparam int MAX_DEGREE = 32;
    localparam int OPER_W     = 32;
    localparam int DEG_W      = 6;
    localparam int SHIFT_W    = 5;
    localparam int PROD_W     = 2 * OPER_W - 1;
    localparam int MOD_W      = OPER_W + 1;
    localparam int BIT_IDX_W  = 6;
    localparam int RED_STEPS  = 8;
    localparam int CLMUL_HALF = OPER_W / 2;
    localparam int CFG_IDX_W  = 2;

    typedef logic [OPER_W-1:0]    oper_t;
    typedef logic [PROD_W-1:0]    prod_t;
    typedef logic [MOD_W-1:0]     mod_t;
    typedef logic [DEG_W-1:0]     deg_t;
    typedef logic [SHIFT_W-1:0]   shift_t;
    typedef logic [BIT_IDX_W-1:0] bit_idx_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t CFG_FIELD_DEGREE   = 2'd0;
    localparam cfg_idx_t CFG_REDUCTION_POLY = 2'd1;

    localparam deg_t  FIELD_DEGREE_RST   = 6'd8;
    localparam oper_t REDUCTION_POLY_RST = 32'd27;

    typedef struct packed {
        logic advance;
        logic valid;
    } pipe_ctl_t;

endpackage

/* src/gf2m_reduce.sv */
module gf2m_reduce
(
    input  logic                clk,
    input  logic                rst_n,
    input  gf2m_pkg::pipe_ctl_t ctl,
    input  gf2m_pkg::bit_idx_t  top_bit,
    input  gf2m_pkg::mod_t      modulus,
    input  gf2m_pkg::prod_t     data_in,
    output logic                valid_out,
    output gf2m_pkg::prod_t     data_out
);

    logic               valid_reg;
    gf2m_pkg::prod_t    data_reg;
    gf2m_pkg::prod_t    data_next;

    // clear up to eight high bits, top first, with the aligned modulus
    always_comb
    begin
        gf2m_pkg::prod_t    work;
        gf2m_pkg::bit_idx_t bit_idx;
        gf2m_pkg::bit_idx_t shamt;
        work = data_in;
        for (int j = 0; j < gf2m_pkg::RED_STEPS; j++)
        begin
            bit_idx = top_bit - gf2m_pkg::bit_idx_t'(j);
            shamt   = bit_idx - gf2m_pkg::bit_idx_t'(gf2m_pkg::OPER_W);
            if ((bit_idx >= gf2m_pkg::bit_idx_t'(gf2m_pkg::OPER_W)) && work[bit_idx])
            begin
                work = work ^ (gf2m_pkg::prod_t'(modulus) << shamt);
            end
        end
        data_next = work;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.advance)
        begin
            valid_reg <= ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.advance && ctl.valid)
        begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

/* src/gf2n_multiplier_top.sv */
// GF(2^n) multiplier in polynomial basis, n from 1 to 32.
// input channel: in_valid / in_stall with operand_a and operand_b; a
// transaction happens when in_valid is high and in_stall is low.
// output channel: out_valid / out_stall with product, same rule.
// configuration: cfg_valid / cfg_ready with cfg_index and cfg_data;
// index 0 sets field_degree, index 1 sets reduction_poly, other indexes
// are dropped. cfg_ready is always high. write only while no transaction
// is in flight.
// one operand pair per cycle sustained while out_stall stays low. the
// pipeline has two carry-less multiply stages, four reduction stages
// that clear product bits 62 down to 32, eight per stage but seven in
// the last, plus input and output registers.
// a stall on the output freezes only the full stages; empty stages keep
// filling, and in_stall rises once every stage holds a transaction.
// reset clears all valid bits and loads degree 8 with modulus 0x1b
// (x^8+x^4+x^3+x+1).
module gf2n_multiplier_top
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  gf2m_pkg::oper_t               operand_a,
    input  gf2m_pkg::oper_t               operand_b,
    output logic                          out_valid,
    input  logic                          out_stall,
    output gf2m_pkg::oper_t               product,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  gf2m_pkg::cfg_idx_t            cfg_index,
    input  gf2m_pkg::oper_t               cfg_data
);

    gf2m_pkg::deg_t     field_degree_reg;
    gf2m_pkg::oper_t    reduction_poly_reg;

    gf2m_pkg::deg_t     deg_eff;
    gf2m_pkg::shift_t   align_shift;
    gf2m_pkg::oper_t    field_mask;
    gf2m_pkg::mod_t     modulus_aligned;

    logic               s1_valid_reg;
    gf2m_pkg::oper_t    s1_a_reg;
    gf2m_pkg::oper_t    s1_b_reg;
    logic               s2_valid_reg;
    gf2m_pkg::oper_t    s2_a_reg;
    gf2m_pkg::oper_t    s2_b_reg;
    gf2m_pkg::prod_t    s2_acc_reg;
    gf2m_pkg::prod_t    s2_acc_next;
    logic               s3_valid_reg;
    gf2m_pkg::prod_t    s3_acc_reg;
    gf2m_pkg::prod_t    s3_acc_next;
    logic               out_valid_reg;
    gf2m_pkg::oper_t    product_reg;
    gf2m_pkg::oper_t    product_next;

    logic               red_valid [4];
    gf2m_pkg::prod_t    red_data  [4];
    gf2m_pkg::pipe_ctl_t red_ctl  [4];

    logic               en_s1;
    logic               en_s2;
    logic               en_s3;
    logic               en_red [4];
    logic               en_out;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_degree_reg   <= gf2m_pkg::FIELD_DEGREE_RST;
            reduction_poly_reg <= gf2m_pkg::REDUCTION_POLY_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                gf2m_pkg::CFG_FIELD_DEGREE:
                begin
                    field_degree_reg <= cfg_data[gf2m_pkg::DEG_W-1:0];
                end
                gf2m_pkg::CFG_REDUCTION_POLY:
                begin
                    reduction_poly_reg <= cfg_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    // operands are aligned so the field top sits at bit 32
    always_comb
    begin
        gf2m_pkg::deg_t shift_wide;
        if (field_degree_reg == '0)
        begin
            deg_eff = gf2m_pkg::deg_t'(1);
        end
        else if (field_degree_reg > gf2m_pkg::deg_t'(gf2m_pkg::MAX_DEGREE))
        begin
            deg_eff = gf2m_pkg::deg_t'(gf2m_pkg::MAX_DEGREE);
        end
        else
        begin
            deg_eff = field_degree_reg;
        end
        shift_wide      = gf2m_pkg::deg_t'(gf2m_pkg::OPER_W) - deg_eff;
        align_shift     = shift_wide[gf2m_pkg::SHIFT_W-1:0];
        field_mask      = {gf2m_pkg::OPER_W{1'b1}} >> align_shift;
        modulus_aligned = {1'b1, (reduction_poly_reg & field_mask) << align_shift};
    end

    // stall chain, back to front
    assign en_out    = !out_valid_reg || !out_stall;
    assign en_red[3] = !red_valid[3] || en_out;
    assign en_red[2] = !red_valid[2] || en_red[3];
    assign en_red[1] = !red_valid[1] || en_red[2];
    assign en_red[0] = !red_valid[0] || en_red[1];
    assign en_s3     = !s3_valid_reg || en_red[0];
    assign en_s2     = !s2_valid_reg || en_s3;
    assign en_s1     = !s1_valid_reg || en_s2;
    assign in_stall  = !en_s1;

    // carry-less multiply, low and high halves of b
    always_comb
    begin
        s2_acc_next = '0;
        for (int k = 0; k < gf2m_pkg::CLMUL_HALF; k++)
        begin
            if (s1_b_reg[k])
            begin
                s2_acc_next = s2_acc_next ^ (gf2m_pkg::prod_t'(s1_a_reg) << k);
            end
        end
    end

    always_comb
    begin
        s3_acc_next = s2_acc_reg;
        for (int k = gf2m_pkg::CLMUL_HALF; k < gf2m_pkg::OPER_W; k++)
        begin
            if (s2_b_reg[k])
            begin
                s3_acc_next = s3_acc_next ^ (gf2m_pkg::prod_t'(s2_a_reg) << k);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en_s1)
            begin
                s1_valid_reg <= in_valid;
            end
            if (en_s2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (en_s3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (en_out)
            begin
                out_valid_reg <= red_valid[3];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_s1 && in_valid)
        begin
            s1_a_reg <= (operand_a & field_mask) << align_shift;
            s1_b_reg <= operand_b & field_mask;
        end
        if (en_s2 && s1_valid_reg)
        begin
            s2_a_reg   <= s1_a_reg;
            s2_b_reg   <= s1_b_reg;
            s2_acc_reg <= s2_acc_next;
        end
        if (en_s3 && s2_valid_reg)
        begin
            s3_acc_reg <= s3_acc_next;
        end
        if (en_out && red_valid[3])
        begin
            product_reg <= product_next;
        end
    end

    // reduction, eight bit positions per stage
    assign red_ctl[0] = '{advance: en_red[0], valid: s3_valid_reg};
    assign red_ctl[1] = '{advance: en_red[1], valid: red_valid[0]};
    assign red_ctl[2] = '{advance: en_red[2], valid: red_valid[1]};
    assign red_ctl[3] = '{advance: en_red[3], valid: red_valid[2]};

    for (genvar g = 0; g < 4; g++)
    begin : g_red
        gf2m_reduce u_reduce
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (red_ctl[g]),
            .top_bit   (gf2m_pkg::bit_idx_t'(gf2m_pkg::PROD_W - 1 - g * gf2m_pkg::RED_STEPS)),
            .modulus   (modulus_aligned),
            .data_in   ((g == 0) ? s3_acc_reg : red_data[(g == 0) ? 0 : g - 1]),
            .valid_out (red_valid[g]),
            .data_out  (red_data[g])
        );
    end

    assign product_next = red_data[3][gf2m_pkg::OPER_W-1:0] >> align_shift;

    assign out_valid = out_valid_reg;
    assign product   = product_reg;

endmodule
